>>> hdl/pcpg_pkg.sv
// Shared types, codes and constant tables of the parametric curve point generator.
`default_nettype none
package pcpg_pkg;

  // Angle width of the trig unit, in 2^-24 turn
  localparam int ANG_BITS = 24;
  // CORDIC datapath widths and start value (gain compensated, Q2.30)
  localparam int CORDIC_XW = 34;
  localparam int CORDIC_ZW = 25;
  localparam logic signed [CORDIC_XW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic [3:0] CORDIC_LAST = 4'd15;
  // 2*pi in Q3.29
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  // 1.1 in Q.15
  localparam logic [16:0] ELL_B_Q15 = 17'd36045;

  typedef enum logic [3:0] {
    SHP_ASTROID  = 4'd0,
    SHP_CYCLOID  = 4'd1,
    SHP_HUYGENS  = 4'd2,
    SHP_HYPO     = 4'd3,
    SHP_LINE     = 4'd4,
    SHP_CIRCLE   = 4'd5,
    SHP_ELLIPSE  = 4'd6,
    SHP_FANCY    = 4'd7,
    SHP_STARFISH = 4'd8
  } shape_t;

  typedef enum logic [2:0] {
    CFG_SHAPE  = 3'd0,
    CFG_SCALE  = 3'd1,
    CFG_CX     = 3'd2,
    CFG_CY     = 3'd3,
    CFG_STEP   = 3'd4,
    CFG_SPAN   = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_TRIG1,
    ST_WAIT1,
    ST_TRIG2,
    ST_WAIT2,
    ST_COORD,
    ST_CUBE,
    ST_SCALE,
    ST_OUT
  } state_t;

  // Request to the trig unit
  typedef struct packed {
    logic                start;
    logic [ANG_BITS-1:0] angle;
  } trig_req_t;

  // Response of the trig unit, Q1.15
  typedef struct packed {
    logic               done;
    logic signed [15:0] cos_v;
    logic signed [15:0] sin_v;
  } trig_rsp_t;

  // CORDIC arctangent table in 2^-24 turn
  function automatic logic [21:0] atan_turn(input logic [3:0] idx);
    logic [21:0] r;
    case (idx)
      4'd0:    r = 22'd2097152;
      4'd1:    r = 22'd1238021;
      4'd2:    r = 22'd654136;
      4'd3:    r = 22'd332050;
      4'd4:    r = 22'd166669;
      4'd5:    r = 22'd83416;
      4'd6:    r = 22'd41718;
      4'd7:    r = 22'd20860;
      4'd8:    r = 22'd10430;
      4'd9:    r = 22'd5215;
      4'd10:   r = 22'd2608;
      4'd11:   r = 22'd1304;
      4'd12:   r = 22'd652;
      4'd13:   r = 22'd326;
      4'd14:   r = 22'd163;
      default: r = 22'd81;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/parametric_curve_point_generator.sv
// Top level: sequencer, phase store, curve evaluation and pixel mapping.
//
// Each accepted request with restart high, or with restart low while a curve is
// running, yields one pixel; a request with restart low while idle is consumed
// with no result. One request is handled at a time; the 16-iteration CORDIC
// unit is run once per point for curves that need one sine/cosine pair and
// twice for huygens, hypo, fancy and starfish. The phase of the next point
// lives in a one-word store with a registered read and is written back when
// the pixel is handed over, except after the last point. Registers are written
// through the cfg port, which is always ready; they must only change while the
// block is idle.
`default_nettype none
module parametric_curve_point_generator #(
  parameter int FRACTION_BITS = 16,
  parameter int TURN_BITS     = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               restart,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      pixel_x,
  output logic signed [15:0]      pixel_y,
  output logic                    last_point,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);
  import pcpg_pkg::*;

  localparam int PB = TURN_BITS + FRACTION_BITS;
  localparam int AW = PB + ANG_BITS - FRACTION_BITS;
  localparam int TW = PB + 32 - (FRACTION_BITS + 14);
  localparam int CW = TW + 3;
  localparam int VW = CW + 10;
  localparam int NW = ((PB > 24) ? PB : 24) + 1;
  localparam logic signed [CW-1:0] K_ONE = CW'(32768);

  // configuration registers
  logic [3:0]  shape_code;
  logic [7:0]  pixel_scale;
  logic [11:0] center_x, center_y;
  logic [15:0] phase_step;
  logic [23:0] phase_span;

  state_t state, state_next;
  logic   running;
  logic   restart_l;

  // phase store and its registered read
  logic [PB-1:0] phase_mem;
  logic [PB-1:0] phase_rd;

  // working registers
  logic [PB-1:0]        ph_w;
  logic [TW-1:0]        t_q;
  logic [AW-1:0]        ang_a;
  logic signed [15:0]   c_q, s_q, c2_q, s2_q;
  logic signed [31:0]   cc_q, ss_q;
  logic signed [CW-1:0] coord_x, coord_y;
  logic signed [VW-1:0] vx, vy;
  logic                 last_q;
  logic [PB-1:0]        next_q;

  // combinational
  logic [PB-1:0]        ph_cur;
  logic [PB+31:0]       tprod;
  logic [25:0]          m15;
  logic [ANG_BITS-1:0]  ang2;
  logic                 need2, go2, out_load, in_acc;
  trig_req_t            treq;
  trig_rsp_t            trsp;
  logic                 div_start, div_done;
  logic [ANG_BITS-1:0]  div_q;
  logic signed [CW-1:0] wc, ws, wc2, ws2, wt, dtx, dty, cx_n, cy_n;
  logic signed [32:0]   ell;
  logic signed [47:0]   cube_x, cube_y;
  logic [NW-1:0]        nxt;
  logic                 last_n;

  function automatic logic signed [15:0] to_pix(input logic signed [VW-1:0] v);
    logic signed [VW-1:0]  adj;
    logic signed [VW-16:0] q;
    adj = v + (v[VW-1] ? VW'(32767) : VW'(0));
    q   = (VW-15)'(adj >>> 15);
    if (q > 32767) begin
      return 16'sh7FFF;
    end else if (q < -32768) begin
      return -16'sh8000;
    end
    return q[15:0];
  endfunction

  pcpg_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (treq),
    .rsp (trsp)
  );

  pcpg_div3 #(.W(AW + 1)) u_div3 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .value ({ang_a, 1'b0}),
    .done  (div_done),
    .quot  (div_q)
  );

  // angle and phase derivations
  always_comb begin
    ph_cur = restart_l ? '0 : phase_rd;
    tprod  = (PB+32)'(ph_cur) * (PB+32)'(TWO_PI_Q29);
    m15    = (ang_a[25:0] << 4) - ang_a[25:0];
    case (shape_code)
      SHP_HUYGENS:  ang2 = ANG_BITS'(ang_a[ANG_BITS-1:0] * 3);
      SHP_HYPO:     ang2 = {ang_a[ANG_BITS-2:0], 1'b0};
      SHP_FANCY:    ang2 = m15[25:2];
      SHP_STARFISH: ang2 = div_q;
      default:      ang2 = ang_a[ANG_BITS-1:0];
    endcase
    need2 = (shape_code == SHP_HUYGENS) || (shape_code == SHP_HYPO) ||
            (shape_code == SHP_FANCY) || (shape_code == SHP_STARFISH);
    go2   = (shape_code != SHP_STARFISH) || div_done;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid && (restart || running)) state_next = ST_READ;
      ST_READ:  state_next = ST_TRIG1;
      ST_TRIG1: state_next = ST_WAIT1;
      ST_WAIT1: if (trsp.done) state_next = need2 ? ST_TRIG2 : ST_COORD;
      ST_TRIG2: if (go2) state_next = ST_WAIT2;
      ST_WAIT2: if (trsp.done) state_next = ST_COORD;
      ST_COORD: state_next = ST_CUBE;
      ST_CUBE:  state_next = ST_SCALE;
      ST_SCALE: state_next = ST_OUT;
      ST_OUT:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall   = (state != ST_IDLE);
    in_acc     = in_valid && !in_stall;
    out_load   = (state == ST_OUT) && (!out_valid || !out_stall);
    div_start  = (state == ST_TRIG1);
    treq.start = (state == ST_TRIG1) || ((state == ST_TRIG2) && go2);
    treq.angle = (state == ST_TRIG2) ? ang2 : ang_a[ANG_BITS-1:0];
    cfg_ready  = 1'b1;
  end

  // curve coordinates in Q.15
  always_comb begin
    wc  = CW'(c_q);
    ws  = CW'(s_q);
    wc2 = CW'(c2_q);
    ws2 = CW'(s2_q);
    wt  = CW'($signed({1'b0, t_q}));
    ell = 33'(s_q) * $signed({16'b0, ELL_B_Q15});
    dtx = '0;
    dty = '0;
    cx_n = '0;
    cy_n = '0;
    case (shape_code)
      SHP_CYCLOID: begin
        dtx  = K_ONE - wc;
        dty  = wt - ws;
        cx_n = ((dtx <<< 1) + dtx) >>> 1;
        cy_n = ((dty <<< 1) + dty) >>> 1;
      end
      SHP_HUYGENS: begin
        cx_n = (wc <<< 3) + (wc <<< 2) - (wc2 <<< 2);
        cy_n = (ws <<< 3) + (ws <<< 2) - (ws2 <<< 2);
      end
      SHP_HYPO: begin
        dtx  = (wc <<< 1) + wc2;
        dty  = (ws <<< 1) - ws2;
        cx_n = ((dtx <<< 1) + dtx) >>> 1;
        cy_n = ((dty <<< 1) + dty) >>> 1;
      end
      SHP_LINE: begin
        cx_n = K_ONE - wt;
        cy_n = K_ONE - wt;
      end
      SHP_CIRCLE: begin
        cx_n = wc;
        cy_n = ws;
      end
      SHP_ELLIPSE: begin
        cx_n = wc <<< 1;
        cy_n = CW'(ell >>> 15);
      end
      SHP_FANCY: begin
        cx_n = (wc <<< 4) - wc - (wc2 <<< 2);
        cy_n = (ws <<< 4) - ws - (ws2 <<< 2);
      end
      SHP_STARFISH: begin
        cx_n = (wc <<< 1) + (wc2 <<< 2) + wc2;
        cy_n = (ws <<< 1) - ((ws2 <<< 2) + ws2);
      end
      default: begin
        cx_n = '0;
        cy_n = '0;
      end
    endcase
    cube_x = 48'(cc_q) * 48'(c_q);
    cube_y = 48'(ss_q) * 48'(s_q);
    nxt    = NW'(ph_w) + NW'(phase_step);
    last_n = (nxt >= NW'(phase_span)) || ((nxt >> PB) != '0);
  end

  // phase store with registered read
  always_ff @(posedge clk) begin
    phase_rd <= phase_mem;
    if (out_load && !last_q) begin
      phase_mem <= next_q;
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      running     <= 1'b0;
      out_valid   <= 1'b0;
      shape_code  <= 4'd0;
      pixel_scale <= 8'd90;
      center_x    <= 12'd200;
      center_y    <= 12'd100;
      phase_step  <= 16'd256;
      phase_span  <= 24'd65536;
    end else begin
      state <= state_next;
      if (in_acc && restart) begin
        running <= 1'b1;
      end else if (out_load && last_q) begin
        running <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHAPE: shape_code  <= cfg_data[3:0];
          CFG_SCALE: pixel_scale <= cfg_data[7:0];
          CFG_CX:    center_x    <= cfg_data[11:0];
          CFG_CY:    center_y    <= cfg_data[11:0];
          CFG_STEP:  phase_step  <= cfg_data[15:0];
          CFG_SPAN:  phase_span  <= cfg_data;
          default:   ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      restart_l <= restart;
    end
    case (state)
      ST_READ: begin
        ph_w  <= ph_cur;
        t_q   <= tprod[PB+31:FRACTION_BITS+14];
        ang_a <= AW'(ph_cur) << (ANG_BITS - FRACTION_BITS);
      end
      ST_WAIT1: if (trsp.done) begin
        c_q  <= trsp.cos_v;
        s_q  <= trsp.sin_v;
        c2_q <= '0;
        s2_q <= '0;
      end
      ST_WAIT2: if (trsp.done) begin
        c2_q <= trsp.cos_v;
        s2_q <= trsp.sin_v;
      end
      ST_COORD: begin
        coord_x <= cx_n;
        coord_y <= cy_n;
        cc_q    <= 32'(c_q) * 32'(c_q);
        ss_q    <= 32'(s_q) * 32'(s_q);
        last_q  <= last_n;
        next_q  <= nxt[PB-1:0];
      end
      ST_CUBE: if (shape_code == SHP_ASTROID) begin
        coord_x <= CW'(cube_x >>> 29);
        coord_y <= CW'(cube_y >>> 29);
      end
      ST_SCALE: begin
        vx <= VW'(coord_x) * VW'($signed({1'b0, pixel_scale})) +
              VW'($signed({1'b0, center_x, 15'b0}));
        vy <= VW'(coord_y) * VW'($signed({1'b0, pixel_scale})) +
              VW'($signed({1'b0, center_y, 15'b0}));
      end
      default: ;
    endcase
    if (out_load) begin
      pixel_x    <= to_pix(vx);
      pixel_y    <= to_pix(vy);
      last_point <= last_q;
    end
  end

  a_restart_go: assert property (@(posedge clk) disable iff (rst)
    in_acc && restart |=> state == ST_READ) else $error("restart request not started");
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT)) else $error("result outside handover");
  a_last_stop: assert property (@(posedge clk) disable iff (rst)
    out_load && last_q |=> !running) else $error("running after last point");

endmodule
`default_nettype wire

>>> hdl/pcpg_cordic.sv
// Iterative CORDIC sine/cosine unit, one micro-rotation per cycle.
`default_nettype none
module pcpg_cordic (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire pcpg_pkg::trig_req_t   req,
  output pcpg_pkg::trig_rsp_t        rsp
);
  import pcpg_pkg::*;

  logic signed [CORDIC_XW-1:0] x, y;
  logic signed [CORDIC_ZW-1:0] z;
  logic [3:0] iter;
  logic [1:0] quad;
  logic       busy;
  logic       done;

  logic signed [CORDIC_XW-1:0] dx, dy, rx, ry, rndx, rndy;
  logic signed [CORDIC_ZW-1:0] at;

  function automatic logic signed [15:0] sat16(input logic signed [CORDIC_XW-1:0] v);
    logic signed [15:0] r;
    if (v > 32767) begin
      r = 16'sh7FFF;
    end else if (v < -32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // micro-rotation terms
  always_comb begin
    dx = y >>> iter;
    dy = x >>> iter;
    at = $signed({3'b000, atan_turn(iter)});
  end

  // rotation iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        x    <= CORDIC_X0;
        y    <= '0;
        z    <= $signed({3'b000, req.angle[ANG_BITS-3:0]});
        quad <= req.angle[ANG_BITS-1:ANG_BITS-2];
        iter <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!z[CORDIC_ZW-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        iter <= iter + 4'd1;
        if (iter == CORDIC_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quadrant fold, round to Q1.15 and saturate
  always_comb begin
    case (quad)
      2'd1:    begin rx = -y; ry = x;  end
      2'd2:    begin rx = -x; ry = -y; end
      2'd3:    begin rx = y;  ry = -x; end
      default: begin rx = x;  ry = y;  end
    endcase
    rndx = (rx + 34'sd16384) >>> 15;
    rndy = (ry + 34'sd16384) >>> 15;
    rsp.done  = done;
    rsp.cos_v = sat16(rndx);
    rsp.sin_v = sat16(rndy);
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("trig request while busy");
  a_done_len: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && $past(iter) == CORDIC_LAST) else $error("early trig done");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("trig done held");

endmodule
`default_nettype wire

>>> hdl/pcpg_div3.sv
// Digit-serial divide by three, four quotient bits per cycle, low 24 bits kept.
`default_nettype none
module pcpg_div3 #(
  parameter int W = 33
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] value,
  output logic              done,
  output logic [pcpg_pkg::ANG_BITS-1:0] quot
);
  import pcpg_pkg::*;

  localparam int NSTEP = (W + 3) / 4;
  localparam int PW    = NSTEP * 4;
  localparam int CNTW  = $clog2(NSTEP + 1);

  logic [PW-1:0]       sh;
  logic [1:0]          rem;
  logic [CNTW-1:0]     cnt;
  logic                busy;
  logic [1:0]          rem_next;
  logic [ANG_BITS-1:0] quot_next;
  logic [2:0]          part;

  // four long-division steps on the top nibble
  always_comb begin
    rem_next  = rem;
    quot_next = quot;
    part      = '0;
    for (int k = 0; k < 4; k++) begin
      part = {rem_next, sh[PW-1-k]};
      if (part >= 3'd3) begin
        rem_next  = 2'(part - 3'd3);
        quot_next = {quot_next[ANG_BITS-2:0], 1'b1};
      end else begin
        rem_next  = part[1:0];
        quot_next = {quot_next[ANG_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      sh   <= PW'(value);
      rem  <= '0;
      quot <= '0;
      cnt  <= CNTW'(NSTEP);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      sh   <= sh << 4;
      rem  <= rem_next;
      quot <= quot_next;
      cnt  <= cnt - CNTW'(1);
      if (cnt == CNTW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
